/* sv/rtwec_pkg.sv */
// shared types and constants for the ring time-window event counter
package rtwec_pkg;

    localparam int SLOT_W  = 10;
    localparam int SEC_W   = 32;
    localparam int USEC_W  = 20;
    localparam int TS_W    = SEC_W + USEC_W;
    localparam int CNT_IN_W = 11;
    localparam int EC_W    = 11;
    localparam int RS_W    = 11;
    localparam int MOD_CNT_W = $clog2(SLOT_W);

    localparam logic [RS_W-1:0] RING_SIZE_RST = RS_W'(1024);

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [SLOT_W-1:0]   slot;
        logic [SEC_W-1:0]    time_sec;
        logic [USEC_W-1:0]   time_usec;
        logic [SEC_W-1:0]    end_sec;
        logic [USEC_W-1:0]   end_usec;
        logic [SLOT_W-1:0]   next_slot;
        logic [CNT_IN_W-1:0] total_count;
    } t_in;

    typedef struct packed {
        logic [EC_W-1:0]   event_count;
        logic [SLOT_W-1:0] first_slot;
        logic              found;
    } t_out;

    typedef struct packed {
        logic le;
        logic ge;
    } t_cmp_flags;

endpackage

/* sv/rtwec_ram.sv */
// generic single-port-write ram with registered read
module rtwec_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/rtwec_cmp.sv */
// timestamp comparator shared by both bound searches
module rtwec_cmp (
    input  logic [rtwec_pkg::TS_W-1:0] i_rec,
    input  logic [rtwec_pkg::TS_W-1:0] i_key,
    output rtwec_pkg::t_cmp_flags      o_flags
);
    import rtwec_pkg::*;

    // seconds in the upper bits, so a raw compare orders sec then usec
    always_comb begin
        o_flags.le = (i_rec <= i_key);
        o_flags.ge = (i_rec >= i_key);
    end

endmodule

/* sv/ring_time_window_event_count.sv */
// top level: timestamp ring with sequenced window search
//
//  channel   signals                          transaction
//  command   start, busy, i_in                start high while busy low
//  result    o_done, o_res                    o_done high for one cycle
//  config    i_cfg_valid, o_cfg_ready, data   valid and ready both high
//
//  a store, or a query with no records, returns its result in the cycle after acceptance
//  a query then reduces next_slot mod the ring size bit by bit; per bound it halves at most
//  SEARCH_STEPS times, then scans ages one at a time until a hit or the range runs out;
//  S_FIN then gives the result, skipped when the start bound is not found; one ram read
//  port, one comparator; reset clears the sequencer and sets the ring size to 1024; ram
//  contents stay undefined until written; results cannot be held off by the receiver
module ring_time_window_event_count #(
    parameter int RING_DEPTH   = 1024,
    parameter int SEARCH_STEPS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rtwec_pkg::t_in                i_in,
    output logic                          o_done,
    output rtwec_pkg::t_out               o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rtwec_pkg::RS_W-1:0]    i_cfg_data
);
    import rtwec_pkg::*;

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int MW     = $clog2(RING_DEPTH + 1);
    localparam int AGW    = MW + 1;
    localparam int STEP_W = $clog2(SEARCH_STEPS + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MOD      = 7'b0000010,
        S_SRCH     = 7'b0000100,
        S_SRCH_CMP = 7'b0001000,
        S_SCAN     = 7'b0010000,
        S_SCAN_CMP = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    t_out   r_res, n_res;
    logic [RS_W-1:0] r_ring_size;

    logic [MW-1:0]        r_m, n_m;
    logic [AGW-1:0]       r_tol, n_tol;
    logic [TS_W-1:0]      r_start_key, n_start_key;
    logic [TS_W-1:0]      r_end_key, n_end_key;
    logic [SLOT_W-1:0]    r_ns, n_ns;
    logic [MW-1:0]        r_rem, n_rem;
    logic [MOD_CNT_W-1:0] r_cnt, n_cnt;
    logic [AGW-1:0]       r_lo, n_lo;
    logic [AGW-1:0]       r_hi, n_hi;
    logic [AGW-1:0]       r_mid, n_mid;
    logic [AGW-1:0]       r_a, n_a;
    logic [AGW-1:0]       r_head, n_head;
    logic [AGW-1:0]       r_tail, n_tail;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_is_end, n_is_end;

    logic [MW-1:0]   m_eff;
    logic [AGW-1:0]  tol_eff;
    logic            slot_ok;
    logic [MW:0]     rem_sh;
    logic [MW-1:0]   rem_nxt;
    logic [AGW-1:0]  mid;
    logic [AGW-1:0]  age_sel;
    logic [AGW:0]    slot_sum;
    logic [AW-1:0]   age_addr;
    logic            ram_wr_en;
    logic            ram_rd_en;
    logic [TS_W-1:0] ram_rd_data;
    logic [TS_W-1:0] key;
    t_cmp_flags      flags;
    logic            bound_hit;
    logic            exhausted;
    logic            hit;

    // effective ring size and record count
    always_comb begin
        int rs;
        int tc;
        int mm;
        rs = int'(r_ring_size);
        tc = int'(i_in.total_count);
        mm = (rs < 2) ? 2 : ((rs > RING_DEPTH) ? RING_DEPTH : rs);
        m_eff   = MW'(mm);
        tol_eff = AGW'((tc > mm) ? mm : tc);
        slot_ok = (int'(i_in.slot) < RING_DEPTH);
    end

    // restoring remainder step for next_slot mod ring size
    always_comb begin
        rem_sh = {r_rem, r_ns[SLOT_W-1]};
        if (rem_sh >= (MW+1)'(r_m)) begin
            rem_nxt = MW'(rem_sh - (MW+1)'(r_m));
        end else begin
            rem_nxt = MW'(rem_sh);
        end
    end

    assign mid = AGW'(((AGW+1)'(r_lo) + (AGW+1)'(r_hi)) >> 1);

    // age to ring slot, wrapping at the ring size
    always_comb begin
        logic [AGW:0] p;
        logic [AGW:0] ag;
        p  = (AGW+1)'(r_rem);
        ag = (AGW+1)'(age_sel);
        if (p >= ag) begin
            slot_sum = p - ag;
        end else begin
            slot_sum = p + (AGW+1)'(r_m) - ag;
        end
        age_addr = AW'(slot_sum);
    end

    assign key = r_is_end ? r_end_key : r_start_key;

    rtwec_ram #(
        .WIDTH (TS_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (AW'(i_in.slot)),
        .i_wr_data ({i_in.time_sec, i_in.time_usec}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (age_addr),
        .o_rd_data (ram_rd_data)
    );

    rtwec_cmp u_cmp (
        .i_rec   (ram_rd_data),
        .i_key   (key),
        .o_flags (flags)
    );

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        n_res       = r_res;
        n_m         = r_m;
        n_tol       = r_tol;
        n_start_key = r_start_key;
        n_end_key   = r_end_key;
        n_ns        = r_ns;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_a         = r_a;
        n_head      = r_head;
        n_tail      = r_tail;
        n_step      = r_step;
        n_is_end    = r_is_end;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        age_sel     = r_a;
        bound_hit   = 1'b0;
        exhausted   = 1'b0;
        hit         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_in.operation == OP_STORE) begin
                        ram_wr_en = slot_ok;
                        n_done    = 1'b1;
                        n_res     = '0;
                    end else begin
                        n_m         = m_eff;
                        n_tol       = tol_eff;
                        n_start_key = {i_in.time_sec, i_in.time_usec};
                        n_end_key   = {i_in.end_sec, i_in.end_usec};
                        n_ns        = i_in.next_slot;
                        n_rem       = '0;
                        n_cnt       = '0;
                        if (tol_eff == '0) begin
                            n_done = 1'b1;
                            n_res  = '0;
                        end else begin
                            n_state = S_MOD;
                        end
                    end
                end
            end
            S_MOD: begin
                n_rem = rem_nxt;
                n_ns  = r_ns << 1;
                n_cnt = r_cnt + MOD_CNT_W'(1);
                if (r_cnt == MOD_CNT_W'(SLOT_W - 1)) begin
                    n_lo     = AGW'(1);
                    n_hi     = r_tol;
                    n_step   = '0;
                    n_is_end = 1'b0;
                    n_state  = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_step == STEP_W'(SEARCH_STEPS) || (r_hi - r_lo) <= AGW'(1)) begin
                    n_a     = r_is_end ? r_lo : r_hi;
                    n_state = S_SCAN;
                end else begin
                    age_sel   = mid;
                    ram_rd_en = 1'b1;
                    n_mid     = mid;
                    n_state   = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (flags.le) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid;
                end
                n_step  = r_step + STEP_W'(1);
                n_state = S_SRCH;
            end
            S_SCAN: begin
                exhausted = r_is_end ? (r_a > r_hi) : (r_a < r_lo);
                if (exhausted) begin
                    bound_hit = 1'b1;
                end else begin
                    ram_rd_en = 1'b1;
                    n_state   = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                hit = r_is_end ? flags.le : flags.ge;
                if (hit) begin
                    bound_hit = 1'b1;
                end else begin
                    n_a     = r_is_end ? (r_a + AGW'(1)) : (r_a - AGW'(1));
                    n_state = S_SCAN;
                end
            end
            S_FIN: begin
                age_sel = r_head;
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_tail <= r_tol && r_head >= r_tail) begin
                    n_res.event_count = EC_W'(r_head - r_tail + AGW'(1));
                    n_res.first_slot  = SLOT_W'(slot_sum);
                    n_res.found       = 1'b1;
                end else begin
                    n_res = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // bound settled: start bound gives the head, end bound the tail
        if (bound_hit) begin
            if (!r_is_end) begin
                if (r_a == '0) begin
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_head   = r_a;
                    n_lo     = AGW'(1);
                    n_hi     = r_tol;
                    n_step   = '0;
                    n_is_end = 1'b1;
                    n_state  = S_SRCH;
                end
            end else begin
                n_tail  = r_a;
                n_state = S_FIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_ring_size <= RING_SIZE_RST;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ring_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res       <= n_res;
        r_m         <= n_m;
        r_tol       <= n_tol;
        r_start_key <= n_start_key;
        r_end_key   <= n_end_key;
        r_ns        <= n_ns;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_a         <= n_a;
        r_head      <= n_head;
        r_tail      <= n_tail;
        r_step      <= n_step;
        r_is_end    <= n_is_end;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

/* tb/sv/testbench.sv */
// testbench for the ring time-window event counter: stores, window queries and ring sizes
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rtwec_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int HALVINGS    = 12;
    localparam int RAND_ITEMS  = 600;
    localparam int LIMIT_CYCLES = 800000;
    localparam int TAIL_CYCLES = 150;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_in             i_in = '0;
    logic            o_done;
    t_out            o_res;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [RS_W-1:0] i_cfg_data = '0;

    ring_time_window_event_count #(
        .RING_DEPTH(DEPTH),
        .SEARCH_STEPS(HALVINGS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_in(i_in),
        .o_done(o_done),
        .o_res(o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [TS_W-1:0] ts_ring [DEPTH];
    bit              slot_written [DEPTH];
    logic [RS_W-1:0] ring_cfg = RING_SIZE_RST;

    t_out pending_results [$];
    int   n_errors = 0;
    int   n_items = 0;
    int   n_stores = 0;
    int   n_queries = 0;
    int   n_hits = 0;
    int   n_cfg = 0;
    int   cycles = 0;

    // sender and stimulus state
    int              burst_left = 0;
    bit              gaps_on = 1'b1;
    int              wptr = 0;
    int              phase_recs = 0;
    logic [SEC_W-1:0]  clk_sec = '0;
    logic [USEC_W-1:0] clk_usec = '0;

    function automatic int ring_mod();
        int m;
        m = int'(ring_cfg);
        if (m < 2) m = 2;
        if (m > DEPTH) m = DEPTH;
        return m;
    endfunction

    function automatic int age_to_slot(int pos, int age, int m);
        return (pos >= age) ? pos - age : pos + m - age;
    endfunction

    function automatic logic [TS_W-1:0] ring_rec(int pos, int age, int m);
        return ts_ring[age_to_slot(pos, age, m) % DEPTH];
    endfunction

    function automatic int locate_bound(logic [TS_W-1:0] key, int tol, int pos, int m,
                                        bit is_end);
        int lo;
        int hi;
        int mid;
        int a;
        int s;
        lo = 1;
        hi = tol;
        mid = (lo + hi) / 2;
        for (s = 0; s < HALVINGS; s++) begin
            if (hi - lo <= 1) break;
            if (ring_rec(pos, mid, m) <= key) hi = mid;
            else lo = mid;
            mid = (lo + hi) / 2;
        end
        if (is_end) begin
            for (a = lo; a <= hi; a++)
                if (ring_rec(pos, a, m) <= key) return a;
            return hi + 1;
        end
        for (a = hi; a >= lo; a--)
            if (ring_rec(pos, a, m) >= key) return a;
        return lo - 1;
    endfunction

    function automatic t_out window_count(t_in it);
        t_out r;
        int   m;
        int   pos;
        int   tol;
        int   head;
        int   tail;
        r = '0;
        if (it.operation == OP_STORE) begin
            ts_ring[it.slot] = {it.time_sec, it.time_usec};
            slot_written[it.slot] = 1'b1;
        end else begin
            m = ring_mod();
            pos = int'(it.next_slot) % m;
            tol = int'(it.total_count);
            if (tol > m) tol = m;
            if (tol != 0) begin
                head = locate_bound({it.time_sec, it.time_usec}, tol, pos, m, 1'b0);
                if (head >= 1) begin
                    tail = locate_bound({it.end_sec, it.end_usec}, tol, pos, m, 1'b1);
                    if (tail <= tol && head >= tail) begin
                        r.event_count = EC_W'(head - tail + 1);
                        r.first_slot  = SLOT_W'(age_to_slot(pos, head, m));
                        r.found       = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // number of consecutive written slots going back in age from pos
    function automatic int written_run(int pos, int m);
        int a;
        for (a = 1; a <= m; a++)
            if (!slot_written[age_to_slot(pos, a, m)]) return a - 1;
        return m;
    endfunction

    function automatic logic [TS_W-1:0] nudge(logic [TS_W-1:0] v);
        case ($urandom_range(0, 3))
            0: return v - 1'b1;
            1: return v + 1'b1;
            default: return v;
        endcase
    endfunction

    function automatic t_in make_store(int slot, logic [SEC_W-1:0] sec, logic [USEC_W-1:0] usec);
        t_in it;
        it.operation   = OP_STORE;
        it.slot        = SLOT_W'(slot);
        it.time_sec    = sec;
        it.time_usec   = usec;
        it.end_sec     = $urandom;
        it.end_usec    = USEC_W'($urandom);
        it.next_slot   = SLOT_W'($urandom);
        it.total_count = CNT_IN_W'($urandom);
        return it;
    endfunction

    function automatic t_in make_query(int nxt, int tot, logic [TS_W-1:0] skey,
                                       logic [TS_W-1:0] ekey);
        t_in it;
        it.operation   = OP_QUERY;
        it.slot        = SLOT_W'($urandom);
        it.time_sec    = skey[TS_W-1:USEC_W];
        it.time_usec   = skey[USEC_W-1:0];
        it.end_sec     = ekey[TS_W-1:USEC_W];
        it.end_usec    = ekey[USEC_W-1:0];
        it.next_slot   = SLOT_W'(nxt);
        it.total_count = CNT_IN_W'(tot);
        return it;
    endfunction

    task automatic idle_cycle();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic issue(input t_in item);
        t_out want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) repeat ($urandom_range(0, 8)) idle_cycle();
        end
        burst_left--;
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = window_count(item);
        pending_results.push_back(want);
        n_items++;
        if (item.operation == OP_STORE) n_stores++;
        else n_queries++;
        if (want.found) n_hits++;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) idle_cycle();
        repeat (4) idle_cycle();
    endtask

    task automatic write_ring_size(input int v);
        drain_results();
        @(negedge i_clk);
        start       <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= RS_W'(v);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        ring_cfg = RS_W'(v);
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void tick_clock();
        int u;
        case ($urandom_range(0, 9))
            0: ;
            1: clk_sec = clk_sec + SEC_W'($urandom_range(1, 100000));
            default: begin
                u = int'(clk_usec) + $urandom_range(1, 700000);
                if (u >= 1000000) begin
                    u = u - 1000000;
                    clk_sec = clk_sec + 1'b1;
                end
                clk_usec = USEC_W'(u);
            end
        endcase
    endfunction

    task automatic store_next();
        int m;
        m = ring_mod();
        tick_clock();
        issue(make_store(wptr, clk_sec, clk_usec));
        wptr = (wptr + 1) % m;
        if (phase_recs < m) phase_recs++;
    endtask

    task automatic store_noise();
        int m;
        int slot;
        m = ring_mod();
        slot = $urandom_range(0, 1) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, m - 1);
        issue(make_store(slot, $urandom, USEC_W'($urandom)));
    endtask

    task automatic query_window(input bit tidy);
        int m;
        int pos;
        int avail;
        int tol;
        int tot;
        int nxt;
        int x;
        int y;
        logic [TS_W-1:0] sk;
        logic [TS_W-1:0] ek;
        logic [TS_W-1:0] swap;
        m = ring_mod();
        pos = tidy ? wptr : $urandom_range(0, m - 1);
        avail = written_run(pos, m);
        if (avail == 0) tol = 0;
        else if (!tidy || $urandom_range(0, 2) == 0) tol = $urandom_range(1, avail);
        else tol = (phase_recs == 0) ? 1 : ((phase_recs < avail) ? phase_recs : avail);
        if (!tidy && $urandom_range(0, 3) == 0) tol = 0;
        tot = tol;
        if (tol == m && $urandom_range(0, 2) == 0) tot = $urandom_range(m, 2047);
        nxt = pos;
        if ($urandom_range(0, 3) == 0) nxt = pos + m * $urandom_range(0, (DEPTH - 1 - pos) / m);
        if (tol == 0 || (!tidy && $urandom_range(0, 1) == 0)) begin
            sk = {$urandom, USEC_W'($urandom)};
            ek = {$urandom, USEC_W'($urandom)};
        end else begin
            x = $urandom_range(1, tol);
            y = $urandom_range(x, tol);
            sk = nudge(ring_rec(pos, y, m));
            ek = nudge(ring_rec(pos, x, m));
            if ($urandom_range(0, 7) == 0) begin
                swap = sk;
                sk = ek;
                ek = swap;
            end
        end
        issue(make_query(nxt, tot, sk, ek));
    endtask

    // empty ring straight after reset
    task automatic test_reset_state();
        issue(make_query(0, 0, '0, '1));
        issue(make_query(1023, 0, '0, '1));
    endtask

    // window edges on a short wrapped run in the full-size ring
    task automatic test_window_bounds();
        issue(make_store(1022, '0, '0));
        issue(make_store(1023, '0, 20'd5));
        issue(make_store(0, 1, '0));
        issue(make_store(1, '1, 20'd999999));
        issue(make_store(2, '1, '1));
        issue(make_query(3, 5, '0, '1));
        issue(make_query(3, 4, '1, '1));
        issue(make_query(3, 3, '0, {32'd0, 20'hFFFFF}));
        issue(make_query(3, 5, {32'd1, 20'd0}, {32'd0, 20'd5}));
        issue(make_query(3, 5, {32'd0, 20'd5}, {32'hFFFFFFFF, 20'd999999}));
    endtask

    // ring size saturation, next slot and record count beyond the ring
    task automatic test_size_limits();
        write_ring_size(0);
        issue(make_store(0, 2, '0));
        issue(make_store(1, 3, '0));
        issue(make_query(1023, 2047, '0, '1));
        write_ring_size(1);
        issue(make_query(2, 2, {32'd3, 20'd0}, {32'd3, 20'd0}));
        write_ring_size(2047);
        issue(make_query(3, 5, {32'd0, 20'd1}, {32'd3, 20'd0}));
        write_ring_size(1500);
        issue(make_query(3, 5, '0, '1));
        write_ring_size(2);
        issue(make_query(0, 1024, {32'd2, 20'd0}, '1));
    endtask

    task automatic test_random_traffic();
        int sizes [10] = '{2, 3, 5, 8, 16, 31, 64, 100, 257, 1024};
        int base;
        int m;
        int k;
        int r;
        base = n_items;
        while (n_items - base < RAND_ITEMS) begin
            r = $urandom_range(0, 10);
            write_ring_size(r == 10 ? $urandom_range(2, DEPTH) : sizes[r]);
            m = ring_mod();
            gaps_on = ($urandom_range(0, 3) != 0);
            wptr = $urandom_range(0, m - 1);
            phase_recs = 0;
            clk_sec = ($urandom_range(0, 7) == 0) ? SEC_W'('1) - SEC_W'($urandom_range(0, 1 << 20))
                                                   : SEC_W'($urandom);
            clk_usec = USEC_W'($urandom_range(0, 999999));
            k = (m <= 32) ? m + $urandom_range(0, m) : $urandom_range(6, 40);
            repeat (k) store_next();
            repeat ($urandom_range(12, 40)) begin
                r = $urandom_range(0, 19);
                if (r < 9) query_window(1'b1);
                else if (r < 15) store_next();
                else if (r < 17) store_noise();
                else if (r < 19) query_window(1'b0);
                else drain_results();
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with nothing expected, got %p", $time, o_res);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.event_count !== want.event_count) begin
                    $display("%0t ns: event_count expected %0d got %0d", $time,
                             want.event_count, o_res.event_count);
                    n_errors++;
                end
                if (o_res.first_slot !== want.first_slot) begin
                    $display("%0t ns: first_slot expected %0d got %0d", $time,
                             want.first_slot, o_res.first_slot);
                    n_errors++;
                end
                if (o_res.found !== want.found) begin
                    $display("%0t ns: found expected %0d got %0d", $time,
                             want.found, o_res.found);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        foreach (ts_ring[i]) begin
            ts_ring[i] = '0;
            slot_written[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_window_bounds();
        test_size_limits();
        test_random_traffic();

        while (pending_results.size() != 0) idle_cycle();
        repeat (TAIL_CYCLES) idle_cycle();

        $display("ran %0d stores and %0d window queries, %0d of them with events in the window",
                 n_stores, n_queries, n_hits);
        $display("ring size written %0d times, saturated values and both extremes included",
                 n_cfg);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
